// File: hdl/crc8fr_pkg.sv
// Shared types, constants and the CRC-8 step function of the frame receiver.
package crc8fr_pkg;

  // Parser phase. The fourth code is unused and is parsed as a header start.
  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_DATA    = 2'd1,
    PH_DISCARD = 2'd2
  } phase_e;

  // What closes a job after its optional body byte.
  typedef enum logic [1:0] {
    END_NONE  = 2'd0,
    END_RESP  = 2'd1,
    END_PEER  = 2'd2,
    END_AVAIL = 2'd3
  } end_e;

  // Result item kinds, as carried on the output tuser.
  typedef enum logic [1:0] {
    KIND_BODY = 2'd0,
    KIND_RESP = 2'd1,
    KIND_DONE = 2'd2,
    KIND_PEER = 2'd3
  } kind_e;

  localparam logic [7:0] CODE_ACK       = 8'd1;
  localparam logic [7:0] CODE_CHECKSUM  = 8'd2;
  localparam logic [7:0] CODE_BUSY      = 8'd3;
  localparam logic [7:0] CODE_AVAILABLE = 8'd4;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_CRC_ERR = 2'd1;
  localparam logic [1:0] STATUS_BUSY    = 2'd2;

  localparam logic [7:0] CRC_INIT   = 8'hFF;
  localparam logic [7:0] CRC_POLY   = 8'h07;
  localparam logic [7:0] CRC_XOROUT = 8'hFF;

  // Fixed leading bytes of a response frame: service 0, length 2.
  localparam logic [7:0] RESP_B0 = 8'h00;
  localparam logic [7:0] RESP_B1 = 8'h02;
  localparam logic [7:0] RESP_B2 = 8'h00;
  localparam int         RespLen = 6;

  localparam int TDATA_IN_W  = 16;
  localparam int TUSER_IN_W  = 1;
  localparam int TDATA_OUT_W = 48;
  localparam int TUSER_OUT_W = 2;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 1;
  localparam logic [REG_IDX_W-1:0] REG_RX_ENABLE = 1'b0;

  function automatic logic [7:0] crc8_step(logic [7:0] r, logic [7:0] b);
    logic [7:0] c;
    c = r ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // CRC state after the first four response bytes (checksum slot taken as 0xFF).
  localparam logic [7:0] RESP_PREFIX_CRC =
    crc8_step(crc8_step(crc8_step(crc8_step(CRC_INIT, RESP_B0), RESP_B1), RESP_B2), 8'hFF);

  typedef struct packed {
    logic       en;
    logic       value;
  } cfg_wr_t;

  // One classified input: an optional body byte and an optional closing burst.
  typedef struct packed {
    logic       body_vld;
    logic [7:0] body;
    end_e       end_kind;
    logic [7:0] svc;
    logic [15:0] len;
    logic [7:0] code;
    logic [1:0] status;
  } job_t;

endpackage

// File: hdl/crc8_framed_packet_receiver_core.sv
// Top level of the CRC-8 framed packet receiver: stream ports, register port, parts.
//
//   channel   direction  handshake             payload
//   s_axis    in         tvalid/tready         tuser: cmd; tdata: rx_byte, buffer_free
//   m_axis    out        tvalid/tready/tlast   tuser: kind; tdata: byte, svc, len, status, code
//   apb       in         psel/penable/pready   rx_enable at byte address 0
//
// Each input item is parsed in the cycle it is accepted; a received byte or command
// causes up to eight result items, sent one a cycle from the job queue through the
// output register unless m_axis_tready stalls it; one input item a cycle unless the queue fills.
// tready falls only while the job queue is full. Reset is asynchronous, active low,
// and clears parser state, the queue pointers and the output valid flag; no clearing pass.
module crc8_framed_packet_receiver_core #(
  parameter int QueueDepth = 4
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // tdata: [7:0] rx_byte, [8] buffer_free, rest zero
  input  logic [crc8fr_pkg::TDATA_IN_W-1:0]     s_axis_tdata,
  // tuser: [0] cmd
  input  logic [crc8fr_pkg::TUSER_IN_W-1:0]     s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // tdata: [7:0] data_byte, [15:8] frame_service, [31:16] frame_length,
  //        [33:32] frame_status, [41:34] peer_code, rest zero
  output logic [crc8fr_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,
  // tuser: [1:0] kind
  output logic [crc8fr_pkg::TUSER_OUT_W-1:0]    m_axis_tuser,
  output logic                                  m_axis_tlast,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [crc8fr_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [crc8fr_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [crc8fr_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                  pready
);
  import crc8fr_pkg::*;

  cfg_wr_t               cfg;
  logic                  rx_enable;
  logic [REG_IDX_W-1:0]  reg_idx;
  logic                  q_full;
  logic                  q_empty;
  logic                  job_push;
  logic                  job_pop;
  job_t                  job_in;
  job_t                  job_head;
  logic [1:0]            kind;
  logic [7:0]            data_byte;
  logic [7:0]            frame_service;
  logic [15:0]           frame_length;
  logic [1:0]            frame_status;
  logic [7:0]            peer_code;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[APB_ADDR_W-1:2];
  assign cfg.en    = psel && penable && pwrite && pready && (reg_idx == REG_RX_ENABLE);
  assign cfg.value = pwdata[0];
  assign prdata    = (reg_idx == REG_RX_ENABLE) ? APB_DATA_W'(rx_enable) : '0;

  crc8fr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .cmd_i         (s_axis_tuser[0]),
    .rx_byte_i     (s_axis_tdata[7:0]),
    .buffer_free_i (s_axis_tdata[8]),
    .cfg_i         (cfg),
    .rx_enable_o   (rx_enable),
    .q_full_i      (q_full),
    .job_push_o    (job_push),
    .job_o         (job_in)
  );

  crc8fr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (job_in),
    .full_o  (q_full),
    .pop_i   (job_pop),
    .job_o   (job_head),
    .empty_o (q_empty)
  );

  crc8fr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (!q_empty),
    .job_i           (job_head),
    .pop_o           (job_pop),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .kind_o          (kind),
    .data_byte_o     (data_byte),
    .frame_service_o (frame_service),
    .frame_length_o  (frame_length),
    .frame_status_o  (frame_status),
    .peer_code_o     (peer_code),
    .last_o          (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, peer_code, frame_status, frame_length, frame_service, data_byte};
  assign m_axis_tuser = kind;

endmodule

// File: hdl/crc8fr_front.sv
// Front part: header parser, CRC check and job classification, one item a cycle while the job queue is not full.
module crc8fr_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                cmd_i,
  input  logic [7:0]          rx_byte_i,
  input  logic                buffer_free_i,
  input  crc8fr_pkg::cfg_wr_t cfg_i,
  output logic                rx_enable_o,
  input  logic                q_full_i,
  output logic                job_push_o,
  output crc8fr_pkg::job_t    job_o
);
  import crc8fr_pkg::*;

  phase_e      phase_q, phase_d;
  logic [1:0]  hdr_idx_q, hdr_idx_d;
  logic [7:0]  svc_q, svc_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  chk_q, chk_d;
  logic [7:0]  crc_q, crc_d;
  logic [15:0] left_q, left_d;
  logic        busy_q, busy_d;
  logic [15:0] peer_q, peer_d;
  logic        rx_en_q, rx_en_d;

  logic        fire;
  logic        do_finish;
  logic        crc_ok;
  logic [15:0] pos;
  job_t        job;

  assign in_ready_o  = !q_full_i;
  assign fire        = in_valid_i && in_ready_o;
  assign rx_enable_o = rx_en_q;
  assign pos         = len_q - left_q;

  always_comb begin
    phase_d   = phase_q;
    hdr_idx_d = hdr_idx_q;
    svc_d     = svc_q;
    len_d     = len_q;
    chk_d     = chk_q;
    crc_d     = crc_q;
    left_d    = left_q;
    busy_d    = busy_q;
    peer_d    = peer_q;
    rx_en_d   = rx_en_q;
    do_finish = 1'b0;
    crc_ok    = 1'b0;
    job       = '0;
    job.end_kind = END_NONE;

    if (fire) begin
      if (cmd_i) begin
        if (busy_q) begin
          job.end_kind = END_AVAIL;
          job.code     = CODE_AVAILABLE;
        end
      end else if (!rx_en_q) begin
        phase_d   = PH_HEADER;
        hdr_idx_d = 2'd0;
        crc_d     = CRC_INIT;
      end else begin
        unique case (phase_q) inside
          PH_DATA, PH_DISCARD: begin
            if (phase_q == PH_DATA) begin
              crc_d = crc8_step(crc_q, rx_byte_i);
              if (pos == 16'd0) begin
                peer_d[7:0] = rx_byte_i;
              end else if (pos == 16'd1) begin
                peer_d[15:8] = rx_byte_i;
              end
              if (svc_q != 8'd0) begin
                job.body_vld = 1'b1;
                job.body     = rx_byte_i;
                job.svc      = svc_q;
                job.len      = len_q;
              end
            end
            left_d = left_q - 16'd1;
            if (left_d == 16'd0) do_finish = 1'b1;
          end
          default: begin
            phase_d = PH_HEADER;
            case (hdr_idx_q)
              2'd0: svc_d = rx_byte_i;
              2'd1: len_d[7:0] = rx_byte_i;
              2'd2: len_d[15:8] = rx_byte_i;
              default: chk_d = rx_byte_i;
            endcase
            // The checksum byte itself is covered as 0xFF.
            crc_d = crc8_step(crc_q, (hdr_idx_q == 2'd3) ? 8'hFF : rx_byte_i);
            if (hdr_idx_q == 2'd3) begin
              hdr_idx_d = 2'd0;
              busy_d    = !buffer_free_i;
              phase_d   = buffer_free_i ? PH_DATA : PH_DISCARD;
              left_d    = len_d;
              peer_d    = '0;
              if (len_d == 16'd0) do_finish = 1'b1;
            end else begin
              hdr_idx_d = hdr_idx_q + 2'd1;
            end
          end
        endcase
      end
    end

    if (do_finish) begin
      // Checked against the CRC that includes this item, before the parser restarts.
      crc_ok = (crc_d ^ CRC_XOROUT) == chk_d;
      if (phase_d == PH_DATA) begin
        if (svc_d != 8'd0) begin
          job.end_kind = END_RESP;
          job.svc      = svc_d;
          job.len      = len_d;
          job.code     = crc_ok ? CODE_ACK : CODE_CHECKSUM;
          job.status   = crc_ok ? STATUS_OK : STATUS_CRC_ERR;
        end else if (crc_ok) begin
          job.end_kind = END_PEER;
          job.svc      = peer_d[7:0];
          job.len      = len_d;
          job.code     = peer_d[15:8];
        end
      end else if (svc_d != 8'd0) begin
        job.end_kind = END_RESP;
        job.svc      = svc_d;
        job.len      = len_d;
        job.code     = CODE_BUSY;
        job.status   = STATUS_BUSY;
      end
      phase_d   = PH_HEADER;
      hdr_idx_d = 2'd0;
      crc_d     = CRC_INIT;
    end

    // The user must write only while idle; the block does not enforce it. Disabling restarts the parser.
    if (cfg_i.en) begin
      rx_en_d = cfg_i.value;
      if (!cfg_i.value) begin
        phase_d   = PH_HEADER;
        hdr_idx_d = 2'd0;
        crc_d     = CRC_INIT;
      end
    end
  end

  assign job_o      = job;
  assign job_push_o = fire && (job.body_vld || (job.end_kind != END_NONE));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      hdr_idx_q <= 2'd0;
      svc_q     <= 8'd0;
      len_q     <= 16'd0;
      chk_q     <= 8'd0;
      crc_q     <= CRC_INIT;
      left_q    <= 16'd0;
      busy_q    <= 1'b0;
      peer_q    <= 16'd0;
      rx_en_q   <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      hdr_idx_q <= hdr_idx_d;
      svc_q     <= svc_d;
      len_q     <= len_d;
      chk_q     <= chk_d;
      crc_q     <= crc_d;
      left_q    <= left_d;
      busy_q    <= busy_d;
      peer_q    <= peer_d;
      rx_en_q   <= rx_en_d;
    end
  end

endmodule

// File: hdl/crc8fr_queue.sv
// Small job queue between the front parser and the back result sequencer.
module crc8fr_queue #(
  parameter int Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  crc8fr_pkg::job_t job_i,
  output logic             full_o,
  input  logic             pop_i,
  output crc8fr_pkg::job_t job_o,
  output logic             empty_o
);
  import crc8fr_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign job_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    if (do_pop)  rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: hdl/crc8fr_back.sv
// Back part: expands each queued job into result items behind an output register.
module crc8fr_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  input  crc8fr_pkg::job_t job_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       kind_o,
  output logic [7:0]       data_byte_o,
  output logic [7:0]       frame_service_o,
  output logic [15:0]      frame_length_o,
  output logic [1:0]       frame_status_o,
  output logic [7:0]       peer_code_o,
  output logic             last_o
);
  import crc8fr_pkg::*;

  logic        body_sent_q, body_sent_d;
  logic [2:0]  step_q, step_d;
  logic        valid_q, valid_d;
  kind_e       kind_q, kind_d;
  logic [7:0]  data_q, data_d;
  logic [7:0]  svc_q, svc_d;
  logic [15:0] len_q, len_d;
  logic [1:0]  status_q, status_d;
  logic [7:0]  code_q, code_d;
  logic        last_q, last_d;

  logic        load;
  logic        emit;
  logic        is_body;
  logic [7:0]  resp_crc;
  logic [7:0]  resp_byte;

  assign load     = !valid_q || out_ready_i;
  assign emit     = job_valid_i && load;
  assign is_body  = job_i.body_vld && !body_sent_q;
  assign resp_crc = crc8_step(crc8_step(RESP_PREFIX_CRC, job_i.svc), job_i.code) ^ CRC_XOROUT;

  always_comb begin
    case (step_q)
      3'd0:    resp_byte = RESP_B0;
      3'd1:    resp_byte = RESP_B1;
      3'd2:    resp_byte = RESP_B2;
      3'd3:    resp_byte = resp_crc;
      3'd4:    resp_byte = job_i.svc;
      3'd5:    resp_byte = job_i.code;
      default: resp_byte = 8'd0;
    endcase
  end

  always_comb begin
    kind_d   = KIND_BODY;
    data_d   = 8'd0;
    svc_d    = job_i.svc;
    len_d    = job_i.len;
    status_d = STATUS_OK;
    code_d   = 8'd0;
    last_d   = 1'b1;

    if (is_body) begin
      data_d = job_i.body;
      last_d = job_i.end_kind == END_NONE;
    end else begin
      case (job_i.end_kind) inside
        END_RESP, END_AVAIL: begin
          if (step_q < 3'(RespLen)) begin
            kind_d = KIND_RESP;
            data_d = resp_byte;
            last_d = (job_i.end_kind == END_AVAIL) && (step_q == 3'(RespLen - 1));
          end else begin
            kind_d   = KIND_DONE;
            status_d = job_i.status;
          end
        end
        END_PEER: begin
          kind_d = KIND_PEER;
          code_d = job_i.code;
        end
        default: last_d = 1'b1;
      endcase
    end

    body_sent_d = body_sent_q;
    step_d      = step_q;
    pop_o       = 1'b0;
    if (emit) begin
      if (last_d) begin
        pop_o       = 1'b1;
        body_sent_d = 1'b0;
        step_d      = 3'd0;
      end else if (is_body) begin
        body_sent_d = 1'b1;
      end else begin
        step_d = step_q + 3'd1;
      end
    end

    valid_d = load ? emit : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      body_sent_q <= 1'b0;
      step_q      <= 3'd0;
      valid_q     <= 1'b0;
    end else begin
      body_sent_q <= body_sent_d;
      step_q      <= step_d;
      valid_q     <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q   <= kind_d;
      data_q   <= data_d;
      svc_q    <= svc_d;
      len_q    <= len_d;
      status_q <= status_d;
      code_q   <= code_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o     = valid_q;
  assign kind_o          = kind_q;
  assign data_byte_o     = data_q;
  assign frame_service_o = svc_q;
  assign frame_length_o  = len_q;
  assign frame_status_o  = status_q;
  assign peer_code_o     = code_q;
  assign last_o          = last_q;

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the CRC-8 framed packet receiver with a built-in frame predictor.
module tb_top;
  import crc8fr_pkg::*;

  localparam int StallLimit   = 4000;
  localparam int SettleCycles = 12;
  localparam int ItemGoal     = 280;
  localparam logic [APB_ADDR_W-1:0] RxEnableAddr = APB_ADDR_W'(REG_RX_ENABLE) << 2;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
    logic       buf_free;
  } link_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic [7:0]  svc;
    logic [15:0] len;
    logic [1:0]  status;
    logic [7:0]  code;
    logic        last;
  } rx_result_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [TDATA_IN_W-1:0]  s_axis_tdata  = '0;
  logic [TUSER_IN_W-1:0]  s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_axis_tdata;
  logic [TUSER_OUT_W-1:0] m_axis_tuser;
  logic                   m_axis_tlast;
  logic                   psel          = 1'b0;
  logic                   penable       = 1'b0;
  logic                   pwrite        = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr         = '0;
  logic [APB_DATA_W-1:0]  pwdata        = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  crc8_framed_packet_receiver_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Receiver state as the predictor sees it.
  logic        m_rx_en;
  phase_e      m_phase;
  logic [1:0]  m_hdr_idx;
  logic [7:0]  m_svc;
  logic [15:0] m_len;
  logic [7:0]  m_hdr_crc;
  logic [7:0]  m_crc;
  logic [15:0] m_left;
  logic        m_busy;
  logic [15:0] m_peer;

  rx_result_t  burst[$];
  rx_result_t  results_due[$];
  link_item_t  link_items[$];
  int          items_queued = 0;
  int          items_taken  = 0;
  int          fail_count   = 0;
  bit          steady       = 1'b0;

  function automatic logic [7:0] crc8_next(logic [7:0] acc, logic [7:0] din);
    logic [7:0] r;
    r = acc ^ din;
    repeat (8) r = {r[6:0], 1'b0} ^ (r[7] ? CRC_POLY : 8'h00);
    return r;
  endfunction

  task automatic emit(kind_e kind, logic [7:0] data, logic [7:0] svc, logic [15:0] len,
                      logic [1:0] status, logic [7:0] code);
    burst.push_back({kind, data, svc, len, status, code, 1'b0});
  endtask

  // Six-byte reply frame: 00 02 00 crc svc code.
  task automatic send_reply(logic [7:0] svc, logic [15:0] len, logic [7:0] code);
    logic [7:0] rb [0:5];
    logic [7:0] acc;
    rb = '{RESP_B0, RESP_B1, RESP_B2, 8'hFF, svc, code};
    acc = CRC_INIT;
    for (int i = 0; i < 6; i++) acc = crc8_next(acc, rb[i]);
    rb[3] = acc ^ CRC_XOROUT;
    for (int i = 0; i < 6; i++) emit(KIND_RESP, rb[i], svc, len, STATUS_OK, 8'd0);
  endtask

  task automatic restart_parse();
    m_phase   = PH_HEADER;
    m_hdr_idx = 2'd0;
    m_crc     = CRC_INIT;
  endtask

  task automatic close_frame();
    logic good;
    good = ((m_crc ^ CRC_XOROUT) == m_hdr_crc);
    if (m_phase == PH_DATA) begin
      if (m_svc != 8'd0) begin
        send_reply(m_svc, m_len, good ? CODE_ACK : CODE_CHECKSUM);
        emit(KIND_DONE, 8'd0, m_svc, m_len, good ? STATUS_OK : STATUS_CRC_ERR, 8'd0);
      end else if (good) begin
        emit(KIND_PEER, 8'd0, m_peer[7:0], m_len, STATUS_OK, m_peer[15:8]);
      end
    end else if (m_phase == PH_DISCARD && m_svc != 8'd0) begin
      send_reply(m_svc, m_len, CODE_BUSY);
      emit(KIND_DONE, 8'd0, m_svc, m_len, STATUS_BUSY, 8'd0);
    end
    restart_parse();
  endtask

  // Works out the results of one accepted item and appends them to results_due.
  task automatic receive_item(link_item_t it);
    logic [15:0] pos;
    logic [7:0]  b;
    rx_result_t  r;
    b = it.rx_byte;
    if (it.cmd) begin
      if (m_busy) send_reply(8'd0, 16'd0, CODE_AVAILABLE);
    end else if (!m_rx_en) begin
      restart_parse();
    end else if (m_phase == PH_DATA || m_phase == PH_DISCARD) begin
      if (m_phase == PH_DATA) begin
        pos = m_len - m_left;
        m_crc = crc8_next(m_crc, b);
        if (pos == 16'd0) m_peer[7:0] = b;
        else if (pos == 16'd1) m_peer[15:8] = b;
        if (m_svc != 8'd0) emit(KIND_BODY, b, m_svc, m_len, STATUS_OK, 8'd0);
      end
      m_left = m_left - 16'd1;
      if (m_left == 16'd0) close_frame();
    end else begin
      m_phase = PH_HEADER;
      case (m_hdr_idx)
        2'd0: m_svc = b;
        2'd1: m_len[7:0] = b;
        2'd2: m_len[15:8] = b;
        default: m_hdr_crc = b;
      endcase
      // The checksum slot enters the CRC as 0xFF.
      m_crc = crc8_next(m_crc, (m_hdr_idx == 2'd3) ? 8'hFF : b);
      if (m_hdr_idx == 2'd3) begin
        m_hdr_idx = 2'd0;
        m_busy    = !it.buf_free;
        m_phase   = m_busy ? PH_DISCARD : PH_DATA;
        m_left    = m_len;
        m_peer    = 16'd0;
        if (m_left == 16'd0) close_frame();
      end else begin
        m_hdr_idx = m_hdr_idx + 2'd1;
      end
    end
    foreach (burst[i]) begin
      r = burst[i];
      r.last = (i == burst.size() - 1);
      results_due.push_back(r);
    end
    burst.delete();
  endtask

  task automatic queue_byte(logic [7:0] b, logic bfree);
    link_items.push_back({1'b0, b, bfree});
    items_queued++;
  endtask

  task automatic queue_return();
    link_items.push_back({1'b1, 8'($urandom), 1'($urandom)});
    items_queued++;
  endtask

  // Header and the first nbody body bytes; bad corrupts one bit of the checksum byte.
  task automatic queue_frame(logic [7:0] svc, logic [15:0] len, int nbody, bit bad,
                             logic bfree);
    logic [7:0] body [$];
    logic [7:0] acc;
    acc = crc8_next(crc8_next(crc8_next(CRC_INIT, svc), len[7:0]), len[15:8]);
    acc = crc8_next(acc, 8'hFF);
    for (int i = 0; i < nbody; i++) begin
      body.push_back(8'($urandom));
      acc = crc8_next(acc, body[i]);
    end
    acc = acc ^ CRC_XOROUT;
    if (bad) acc = acc ^ (8'd1 << $urandom_range(0, 7));
    queue_byte(svc, 1'($urandom));
    queue_byte(len[7:0], 1'($urandom));
    queue_byte(len[15:8], 1'($urandom));
    queue_byte(acc, bfree);
    foreach (body[i]) queue_byte(body[i], 1'($urandom));
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (items_taken != items_queued || results_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == RxEnableAddr) begin
      m_rx_en = value[0];
      if (!value[0]) restart_parse();
    end
  endtask

  // Disabling the receiver drops any half-parsed frame, so the next bytes start a header.
  task automatic resync_receiver();
    wait_drained();
    apb_write(RxEnableAddr, 32'd0);
    queue_byte(8'($urandom), 1'($urandom));
    queue_return();
    wait_drained();
    apb_write(RxEnableAddr, 32'd1);
  endtask

  link_item_t on_wire;
  int         send_gap = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        receive_item(on_wire);
        items_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0 || link_items.size() == 0) begin
          if (send_gap > 0) send_gap--;
          s_axis_tvalid <= 1'b0;
        end else begin
          on_wire = link_items.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {7'd0, on_wire.buf_free, on_wire.rx_byte};
          s_axis_tuser  <= on_wire.cmd;
          if (!steady && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 3);
        end
      end
    end
  end

  int stall_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (!steady && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 3);
    end
  end

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    rx_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (results_due.size() == 0) begin
        $error("result item with none expected: kind %0d, tdata %h",
               m_axis_tuser, m_axis_tdata);
        fail_count++;
      end else begin
        want = results_due.pop_front();
        check_field("kind", want.kind, m_axis_tuser);
        check_field("data_byte", want.data, m_axis_tdata[7:0]);
        check_field("frame_service", want.svc, m_axis_tdata[15:8]);
        check_field("frame_length", want.len, m_axis_tdata[31:16]);
        check_field("frame_status", want.status, m_axis_tdata[33:32]);
        check_field("peer_code", want.code, m_axis_tdata[41:34]);
        check_field("last", want.last, m_axis_tlast);
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("** crc8_framed_packet_receiver_core: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [7:0] svc;
    int         len;
    int         tail;
    m_rx_en   = 1'b0;
    m_svc     = 8'd0;
    m_len     = 16'd0;
    m_hdr_crc = 8'd0;
    m_left    = 16'd0;
    m_busy    = 1'b0;
    m_peer    = 16'd0;
    restart_parse();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Receiver is disabled out of reset, so this byte is dropped.
    queue_byte(8'hA5, 1'b1);
    wait_drained();
    apb_write(RxEnableAddr, 32'd1);
    queue_frame(8'hFF, 16'd0, 0, 1'b0, 1'b1);
    queue_frame(8'h01, 16'd1, 1, 1'b1, 1'b1);
    queue_frame(8'h00, 16'd2, 2, 1'b0, 1'b1);
    // Service-0 frame with one body byte: the missing code byte reads as zero.
    queue_frame(8'h00, 16'd1, 1, 1'b0, 1'b1);
    queue_frame(8'h05, 16'd1, 1, 1'b0, 1'b0);
    queue_return();
    queue_frame(8'h80, 16'hFFFF, 1, 1'b0, 1'b1);
    resync_receiver();

    while (items_queued < ItemGoal) begin
      steady = (items_queued >= ItemGoal - 60);
      repeat ($urandom_range(5, 8)) begin
        if ($urandom_range(0, 7) == 0) begin
          queue_return();
        end else begin
          svc = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 4);
          queue_frame(svc, 16'(len), len, $urandom_range(0, 4) == 0,
                      $urandom_range(0, 4) != 0);
        end
      end
      // Broken tail: a long frame cut short, or stray bytes that knock the framing off.
      tail = $urandom_range(0, 2);
      if (tail == 1) begin
        queue_frame(8'($urandom), 16'($urandom_range(8, 65535)), $urandom_range(0, 5),
                    1'b0, 1'($urandom));
      end else if (tail == 2) begin
        repeat ($urandom_range(1, 6)) queue_byte(8'($urandom), 1'($urandom));
      end
      resync_receiver();
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("** crc8_framed_packet_receiver_core: PASSED **");
    end else begin
      $display("** crc8_framed_packet_receiver_core: FAILED **");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/crc8fr_pkg.sv
hdl/crc8fr_front.sv
hdl/crc8fr_queue.sv
hdl/crc8fr_back.sv
hdl/crc8_framed_packet_receiver_core.sv
tb/tb_top.sv
